[rtl/cursor_linked_list_engine_top_macros.svh]
// Assertion macros for the cursor-linked list engine checker.
// Needs a clk and an rst signal in the scope where a macro is used.
`ifndef CURSOR_LINKED_LIST_ENGINE_TOP_MACROS_SVH
`define CURSOR_LINKED_LIST_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, off during reset.
`define CLLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define CLLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/clle_pkg.sv]
// Shared types, codes and the microcode table of the cursor-linked list engine.
// No dependencies; used by clle_useq, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package clle_pkg;

  // Request and response payloads
  typedef struct packed {
    logic        kind;
    logic [7:0]  position;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] length;
  } rsp_t;

  // Request kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DELETE = 1'b1;

  // Response status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Microprogram address
  typedef logic [3:0] upc_t;

  localparam upc_t UA_CHK = 4'd0;   // range check, load walk
  localparam upc_t UA_KND = 4'd1;   // split on kind, read free head
  localparam upc_t UA_IN1 = 4'd2;   // take free slot
  localparam upc_t UA_IN2 = 4'd3;   // unlink it from the free chain
  localparam upc_t UA_WST = 4'd4;   // first walk step
  localparam upc_t UA_WLP = 4'd5;   // walk loop
  localparam upc_t UA_WDN = 4'd6;   // read link of predecessor
  localparam upc_t UA_IW1 = 4'd7;   // new slot takes predecessor's link
  localparam upc_t UA_IW2 = 4'd8;   // predecessor points at new slot
  localparam upc_t UA_DL1 = 4'd9;   // take victim
  localparam upc_t UA_DL2 = 4'd10;  // bypass victim
  localparam upc_t UA_DL3 = 4'd11;  // victim links to free head
  localparam upc_t UA_DL4 = 4'd12;  // victim becomes free head
  localparam upc_t UA_RNG = 4'd13;
  localparam upc_t UA_FUL = 4'd14;
  localparam upc_t UA_RSP = 4'd15;  // hand result to output register

  // Link read address source
  typedef enum logic [1:0] {
    RS_CUR  = 2'd0,
    RS_DATA = 2'd1,
    RS_ZERO = 2'd2
  } rd_sel_t;

  // Link write address source
  typedef enum logic [1:0] {
    WA_ZERO = 2'd0,
    WA_CUR  = 2'd1,
    WA_SLOT = 2'd2
  } wa_sel_t;

  // Link write data source
  typedef enum logic {
    WD_DATA = 1'b0,
    WD_SLOT = 1'b1
  } wd_sel_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NEVER      = 3'd0,
    C_ALWAYS     = 3'd1,
    C_RANGE_BAD  = 3'd2,
    C_IS_DEL     = 3'd3,
    C_RD_END     = 3'd4,
    C_STEPS_ZERO = 3'd5,
    C_STEPS_NZ   = 3'd6
  } cond_t;

  // One control word
  typedef struct packed {
    rd_sel_t    rd_sel;
    logic       wr_en;
    wa_sel_t    wa_sel;
    wd_sel_t    wd_sel;
    logic       val_wr;
    logic       walk_ld;
    logic       step_dec;
    logic       cur_ld;
    logic       slot_ld;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       st_ld;
    logic [1:0] status;
    cond_t      cond;
    upc_t       target;
    logic       rsp;
  } ctrl_t;

  // Datapath flags seen by the sequencer
  typedef struct packed {
    logic range_bad;
    logic is_del;
    logic rd_end;
    logic steps_zero;
  } flags_t;

  // Microprogram
  function automatic ctrl_t ucode(input upc_t pc);
    ctrl_t w;
    w = '0;
    case (pc)
      UA_CHK: begin
        w.walk_ld = 1'b1;
        w.cond    = C_RANGE_BAD;
        w.target  = UA_RNG;
      end
      UA_KND: begin
        w.rd_sel = RS_ZERO;
        w.cond   = C_IS_DEL;
        w.target = UA_WST;
      end
      UA_IN1: begin
        w.slot_ld = 1'b1;
        w.rd_sel  = RS_DATA;
        w.cond    = C_RD_END;
        w.target  = UA_FUL;
      end
      UA_IN2: begin
        w.wr_en  = 1'b1;
        w.wa_sel = WA_ZERO;
        w.wd_sel = WD_DATA;
        w.val_wr = 1'b1;
      end
      UA_WST: begin
        w.rd_sel   = RS_CUR;
        w.step_dec = 1'b1;
        w.cond     = C_STEPS_ZERO;
        w.target   = UA_WDN;
      end
      UA_WLP: begin
        w.cur_ld   = 1'b1;
        w.rd_sel   = RS_DATA;
        w.step_dec = 1'b1;
        w.cond     = C_STEPS_NZ;
        w.target   = UA_WLP;
      end
      UA_WDN: begin
        w.rd_sel = RS_CUR;
        w.cond   = C_IS_DEL;
        w.target = UA_DL1;
      end
      UA_IW1: begin
        w.wr_en  = 1'b1;
        w.wa_sel = WA_SLOT;
        w.wd_sel = WD_DATA;
      end
      UA_IW2: begin
        w.wr_en   = 1'b1;
        w.wa_sel  = WA_CUR;
        w.wd_sel  = WD_SLOT;
        w.cnt_inc = 1'b1;
        w.st_ld   = 1'b1;
        w.status  = ST_OK;
        w.cond    = C_ALWAYS;
        w.target  = UA_RSP;
      end
      UA_DL1: begin
        w.slot_ld = 1'b1;
        w.rd_sel  = RS_DATA;
        w.cond    = C_RD_END;
        w.target  = UA_RNG;
      end
      UA_DL2: begin
        w.wr_en  = 1'b1;
        w.wa_sel = WA_CUR;
        w.wd_sel = WD_DATA;
        w.rd_sel = RS_ZERO;
      end
      UA_DL3: begin
        w.wr_en  = 1'b1;
        w.wa_sel = WA_SLOT;
        w.wd_sel = WD_DATA;
      end
      UA_DL4: begin
        w.wr_en   = 1'b1;
        w.wa_sel  = WA_ZERO;
        w.wd_sel  = WD_SLOT;
        w.cnt_dec = 1'b1;
        w.st_ld   = 1'b1;
        w.status  = ST_OK;
        w.cond    = C_ALWAYS;
        w.target  = UA_RSP;
      end
      UA_RNG: begin
        w.st_ld  = 1'b1;
        w.status = ST_RANGE;
        w.cond   = C_ALWAYS;
        w.target = UA_RSP;
      end
      UA_FUL: begin
        w.st_ld  = 1'b1;
        w.status = ST_FULL;
        w.cond   = C_ALWAYS;
        w.target = UA_RSP;
      end
      UA_RSP: begin
        w.rsp = 1'b1;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = UA_RSP;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[rtl/clle_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module clle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[rtl/clle_useq.sv]
// Microcode sequencer: step counter, control table and conditional jumps.
// Depends on clle_pkg for the control word, flags and microprogram.
`timescale 1ns / 1ps
`default_nettype none

module clle_useq (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire clle_pkg::flags_t flags,
  input  wire logic             rsp_free,
  output clle_pkg::ctrl_t       ctrl,
  output logic                  busy
);

  clle_pkg::upc_t  pc;
  clle_pkg::upc_t  pc_next;
  logic            busy_next;
  clle_pkg::ctrl_t word;
  logic            taken;

  assign word = clle_pkg::ucode(pc);
  // Idle cycles issue a no-op word
  assign ctrl = busy ? word : '0;

  // Jump condition
  always_comb begin
    case (word.cond)
      clle_pkg::C_NEVER:      taken = 1'b0;
      clle_pkg::C_ALWAYS:     taken = 1'b1;
      clle_pkg::C_RANGE_BAD:  taken = flags.range_bad;
      clle_pkg::C_IS_DEL:     taken = flags.is_del;
      clle_pkg::C_RD_END:     taken = flags.rd_end;
      clle_pkg::C_STEPS_ZERO: taken = flags.steps_zero;
      clle_pkg::C_STEPS_NZ:   taken = !flags.steps_zero;
      default:                taken = 1'b0;
    endcase
  end

  // Next step; the response step holds until the output register frees up
  always_comb begin
    pc_next   = pc;
    busy_next = busy;
    if (!busy) begin
      if (start) begin
        busy_next = 1'b1;
        pc_next   = clle_pkg::UA_CHK;
      end
    end else if (word.rsp) begin
      if (rsp_free) begin
        busy_next = 1'b0;
      end
    end else begin
      pc_next = taken ? word.target : clle_pkg::upc_t'(pc + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= clle_pkg::UA_CHK;
    end else begin
      busy <= busy_next;
      pc   <= pc_next;
    end
  end

endmodule

`default_nettype wire

[rtl/cursor_linked_list_engine_top.sv]
// Cursor-linked list engine: top level with the link datapath and stores.
// Depends on clle_pkg, clle_ram and clle_useq.
`timescale 1ns / 1ps
`default_nettype none

// Keeps an ordered list in SLOTS slots: slot 0 heads the free chain, slot
// SLOTS-1 heads the list, so SLOTS-2 elements fit. A request inserts a value
// at a 1-based position or deletes the element at a position, and answers
// with a status (ok, position out of range, no free slot) and the new length.
// One request is worked at a time by a microcoded sequencer over a link RAM
// with one read and one write per cycle; the walk to the predecessor follows
// one link per cycle. The next request can be taken in the cycle after the
// response is loaded. The response sits in an output register, so the next
// request is taken while it waits. After reset a clearing pass builds the
// free chain in the link RAM; requests are stalled until it ends.
module cursor_linked_list_engine_top #(
  parameter int SLOTS      = 256,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire clle_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output clle_pkg::rsp_t      rsp
);

  localparam int AW = $clog2(SLOTS);
  localparam int CW = ((AW > 8) ? AW : 8) + 1;
  localparam logic [AW-1:0] HEAD      = AW'(SLOTS - 1);
  localparam logic [AW-1:0] LAST_FREE = AW'(SLOTS - 2);

  clle_pkg::req_t   req_q;
  clle_pkg::ctrl_t  ctrl;
  clle_pkg::flags_t flags;
  logic             busy;
  logic             start;
  logic             rsp_free;
  logic             ld_rsp;

  logic [AW-1:0] cur;
  logic [AW-1:0] slot;
  logic [7:0]    steps;
  logic [AW-1:0] count;
  logic [1:0]    status;
  logic          init;
  logic [AW-1:0] init_idx;

  logic [AW-1:0] link_rd;
  logic [AW-1:0] link_ra;
  logic [AW-1:0] link_wa;
  logic [AW-1:0] link_wd;
  logic          link_we;

  logic [CW-1:0] pos_w;
  logic [CW-1:0] lim_w;

  // Handshakes
  assign req_stall = busy || init;
  assign start     = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign ld_rsp    = ctrl.rsp && rsp_free;

  // Flags for the sequencer
  assign pos_w = CW'(req_q.position);
  assign lim_w = (req_q.kind == clle_pkg::KIND_DELETE) ? CW'(count)
                                                       : CW'(count) + CW'(1);
  assign flags.range_bad  = (pos_w == '0) || (pos_w > lim_w);
  assign flags.is_del     = (req_q.kind == clle_pkg::KIND_DELETE);
  assign flags.rd_end     = (link_rd == '0) || (link_rd == HEAD);
  assign flags.steps_zero = (steps == 8'd0);

  clle_useq u_useq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .flags    (flags),
    .rsp_free (rsp_free),
    .ctrl     (ctrl),
    .busy     (busy)
  );

  // Link read address
  always_comb begin
    case (ctrl.rd_sel)
      clle_pkg::RS_CUR:  link_ra = cur;
      clle_pkg::RS_DATA: link_ra = link_rd;
      clle_pkg::RS_ZERO: link_ra = '0;
      default:           link_ra = cur;
    endcase
  end

  // Link write port; the clearing pass owns it after reset
  always_comb begin
    if (init) begin
      link_we = 1'b1;
      link_wa = init_idx;
      link_wd = (init_idx >= LAST_FREE) ? '0 : init_idx + AW'(1);
    end else begin
      link_we = ctrl.wr_en;
      case (ctrl.wa_sel)
        clle_pkg::WA_ZERO: link_wa = '0;
        clle_pkg::WA_CUR:  link_wa = cur;
        clle_pkg::WA_SLOT: link_wa = slot;
        default:           link_wa = '0;
      endcase
      link_wd = (ctrl.wd_sel == clle_pkg::WD_SLOT) ? slot : link_rd;
    end
  end

  clle_ram #(
    .WIDTH (AW),
    .DEPTH (SLOTS)
  ) u_link (
    .clk     (clk),
    .wr_en   (link_we),
    .wr_addr (link_wa),
    .wr_data (link_wd),
    .rd_addr (link_ra),
    .rd_data (link_rd)
  );

  // Element data; written on insert, kept for the slot
  clle_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (SLOTS)
  ) u_val (
    .clk     (clk),
    .wr_en   (ctrl.val_wr),
    .wr_addr (slot),
    .wr_data (DATA_WIDTH'(req_q.value)),
    .rd_addr (slot),
    .rd_data ()
  );

  // Control state: clearing pass, element count, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      init      <= 1'b1;
      init_idx  <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (init) begin
        init_idx <= init_idx + AW'(1);
        if (init_idx == HEAD) begin
          init <= 1'b0;
        end
      end
      if (ctrl.cnt_inc) begin
        count <= count + AW'(1);
      end else if (ctrl.cnt_dec) begin
        count <= count - AW'(1);
      end
      rsp_valid <= ld_rsp || (rsp_valid && rsp_stall);
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      req_q <= req;
    end
    if (ctrl.walk_ld) begin
      cur   <= HEAD;
      steps <= req_q.position - 8'd1;
    end else begin
      if (ctrl.cur_ld) begin
        cur <= link_rd;
      end
      if (ctrl.step_dec) begin
        steps <= steps - 8'd1;
      end
    end
    if (ctrl.slot_ld) begin
      slot <= link_rd;
    end
    if (ctrl.st_ld) begin
      status <= ctrl.status;
    end
    if (ld_rsp) begin
      rsp.status <= status;
      rsp.length <= 8'(count);
    end
  end

endmodule

`default_nettype wire

[rtl/clle_chk.sv]
// Port-level checker for the cursor-linked list engine, bound to the top level.
// Depends on clle_pkg and cursor_linked_list_engine_top_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "cursor_linked_list_engine_top_macros.svh"

module clle_chk (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           req_valid,
  input wire logic           req_stall,
  input wire clle_pkg::req_t req,
  input wire logic           rsp_valid,
  input wire logic           rsp_stall,
  input wire clle_pkg::rsp_t rsp
);

  logic       req_acc;
  logic       rsp_acc;
  logic       rsp_wait;
  logic       rej_acc;
  logic       ok_acc;
  logic       len_step;
  logic [7:0] last_len;

  assign req_acc  = req_valid && !req_stall;
  assign rsp_acc  = rsp_valid && !rsp_stall;
  assign rsp_wait = rsp_valid && rsp_stall;
  assign rej_acc  = rsp_acc && (rsp.status != clle_pkg::ST_OK);
  assign ok_acc   = rsp_acc && (rsp.status == clle_pkg::ST_OK);
  // A successful request moves the length by exactly one
  assign len_step = (rsp.length == last_len + 8'd1) || (rsp.length == last_len - 8'd1);

  // Track the last delivered length
  always_ff @(posedge clk) begin
    if (rst) begin
      last_len <= 8'd0;
    end else begin
      if (rsp_acc) begin
        last_len <= rsp.length;
      end
    end
  end

  `CLLE_ASSERT_NEXT(a_rsp_hold, rsp_wait, rsp_valid && $stable(rsp), "response moved while stalled")
  `CLLE_ASSERT_NEXT(a_one_at_a_time, req_acc, req_stall, "request taken while one is in work")
  `CLLE_ASSERT_NOW(a_reject_keeps_len, rej_acc, rsp.length == last_len, "reject moved length")
  `CLLE_ASSERT_NOW(a_ok_moves_len, ok_acc, len_step, "length off by more than one")

endmodule

bind cursor_linked_list_engine_top clle_chk u_chk (.*);

`default_nettype wire
